>>> rtl/core/spa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants for the slot pool allocator: request and result
// beats, status codes, request modes and the default slot count.
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int SPA_MAX_SLOTS = 64;
    localparam int SLOT_W        = 6;
    localparam int POOL_W        = 7;
    localparam int STATUS_W      = 3;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_FREE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RECYCLED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted_slot;
        logic [STATUS_W-1:0] status;
    } t_res;

endpackage
`default_nettype wire

>>> rtl/core/slot_pool_allocator_oldest_evict.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slot_pool_allocator_oldest_evict
// Slot allocator with oldest-first recycling, keeping the age order of the
// active slots as a doubly linked list in two synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken on a rising edge where start is high and busy is
//   low. An allocate grants the lowest free slot below the pool size; when all
//   usable slots are active it reissues the oldest active slot and moves it to
//   the young end of the list. A release unlinks the named slot.
//   Every request produces exactly one result beat, shown on o_res for one
//   cycle with o_res_valid high. The receiver cannot stall; it must take it.
//   A free grant, a one-entry recycle or a rejected request is answered from
//   the evaluate state; a request that must read the link memories (recycle
//   of a list with two or more entries, or release) passes on to the finish
//   state, as the read data of the link memories is registered. Busy drops
//   with the result, so a new request can be taken in the cycle the result is
//   shown; no request is taken before the result of the last one is shown.
//   The pool size register is written over the config channel while idle;
//   o_cfg_ready is high whenever the block is not busy.
//   Reset clears the active flags, the list count and the pool size. Link
//   memory contents are never read before they are written.
// ----------------------------------------------------------------------------
module slot_pool_allocator_oldest_evict
    import spa_pkg::*;
#(
    parameter int MAX_SLOTS = SPA_MAX_SLOTS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_req              i_req,
    output logic                   o_res_valid,
    output t_res                   o_res,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [POOL_W-1:0] i_cfg_data
);

    // IW and CW follow the slot count; LW is the larger of CW and POOL_W.
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int LW = (CW > POOL_W) ? CW : POOL_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [MAX_SLOTS-1:0] r_active, n_active;
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_head, n_head;
    logic [IW-1:0]       r_tail, n_tail;
    logic [POOL_W-1:0]   r_pool;
    t_req                r_req;
    logic                r_res_valid, n_res_valid;
    t_res                r_res, n_res;

    logic [LW-1:0]       limit;
    logic [IW-1:0]       slot_idx;
    logic                slot_ok;
    logic                free_found;
    logic [IW-1:0]       free_idx;

    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       rd_next;
    logic [IW-1:0]       rd_prev;
    logic                next_we;
    logic [IW-1:0]       next_addr;
    logic [IW-1:0]       next_data;
    logic                prev_we;
    logic [IW-1:0]       prev_addr;
    logic [IW-1:0]       prev_data;

    // A pool size above the built slot count acts as the built slot count.
    assign limit = (LW'(r_pool) > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : LW'(r_pool);

    assign slot_idx = IW'(r_req.slot);

    // A slot is in the age list exactly when its active flag is set, so the
    // release check needs no list walk.
    assign slot_ok = (LW'(r_req.slot) < limit) && r_active[slot_idx];

    // Release reads the links of the named slot, recycle reads the head's
    // forward link.
    assign rd_addr = (r_req.mode == MODE_RELEASE) ? slot_idx : r_head;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    spa_free_search #(
        .DEPTH (MAX_SLOTS),
        .IW    (IW),
        .LW    (LW)
    ) u_free_search (
        .i_active (r_active),
        .i_limit  (limit),
        .o_found  (free_found),
        .o_idx    (free_idx)
    );

    spa_link_mem #(
        .DEPTH (MAX_SLOTS),
        .IW    (IW)
    ) u_link_mem (
        .i_clk       (i_clk),
        .i_rd_addr   (rd_addr),
        .o_rd_next   (rd_next),
        .o_rd_prev   (rd_prev),
        .i_next_we   (next_we),
        .i_next_addr (next_addr),
        .i_next_data (next_data),
        .i_prev_we   (prev_we),
        .i_prev_addr (prev_addr),
        .i_prev_data (prev_data)
    );

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_res_valid = 1'b0;
        n_res       = r_res;
        next_we     = 1'b0;
        next_addr   = r_tail;
        next_data   = '0;
        prev_we     = 1'b0;
        prev_addr   = '0;
        prev_data   = r_tail;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_req.mode == MODE_ALLOC) begin
                    if (free_found) begin
                        // Append the free slot at the young end of the list.
                        n_active[free_idx] = 1'b1;
                        if (r_count == '0) begin
                            n_head = free_idx;
                        end else begin
                            next_we   = 1'b1;
                            next_addr = r_tail;
                            next_data = free_idx;
                            prev_we   = 1'b1;
                            prev_addr = free_idx;
                            prev_data = r_tail;
                        end
                        n_tail           = free_idx;
                        n_count          = r_count + CW'(1);
                        n_res_valid      = 1'b1;
                        n_res.granted_slot = SLOT_W'(free_idx);
                        n_res.status     = ST_FREE;
                        n_state          = S_IDLE;
                    end else if (r_count == CW'(1)) begin
                        // A single entry is both oldest and youngest.
                        n_res_valid        = 1'b1;
                        n_res.granted_slot = SLOT_W'(r_head);
                        n_res.status       = ST_RECYCLED;
                        n_state            = S_IDLE;
                    end else if (r_count != '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_res_valid        = 1'b1;
                        n_res.granted_slot = '0;
                        n_res.status       = ST_NONE;
                        n_state            = S_IDLE;
                    end
                end else begin
                    if (slot_ok) begin
                        n_state = S_FIN;
                    end else begin
                        n_res_valid        = 1'b1;
                        n_res.granted_slot = '0;
                        n_res.status       = ST_IGNORED;
                        n_state            = S_IDLE;
                    end
                end
            end
            S_FIN: begin
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
                if (r_req.mode == MODE_ALLOC) begin
                    // Move the head to the tail; the head's successor leads.
                    n_head             = rd_next;
                    next_we            = 1'b1;
                    next_addr          = r_tail;
                    next_data          = r_head;
                    prev_we            = 1'b1;
                    prev_addr          = r_head;
                    prev_data          = r_tail;
                    n_tail             = r_head;
                    n_res.granted_slot = SLOT_W'(r_head);
                    n_res.status       = ST_RECYCLED;
                end else begin
                    // Unlink the slot; the head's backward link and the tail's
                    // forward link are never used.
                    n_active[slot_idx] = 1'b0;
                    n_count            = r_count - CW'(1);
                    if (slot_idx == r_head && slot_idx == r_tail) begin
                        n_head = r_head;
                    end else if (slot_idx == r_head) begin
                        n_head = rd_next;
                    end else if (slot_idx == r_tail) begin
                        n_tail = rd_prev;
                    end else begin
                        next_we   = 1'b1;
                        next_addr = rd_prev;
                        next_data = rd_next;
                        prev_we   = 1'b1;
                        prev_addr = rd_next;
                        prev_data = rd_prev;
                    end
                    n_res.granted_slot = r_req.slot;
                    n_res.status       = ST_RELEASED;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_count     <= '0;
            r_pool      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pool <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
        r_res  <= n_res;
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/spa_link_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spa_link_mem
// Forward and backward link memories of the age-ordered slot list. One shared
// read address, registered read data, one write port on each memory.
// ----------------------------------------------------------------------------
module spa_link_mem
    import spa_pkg::*;
#(
    parameter int DEPTH = SPA_MAX_SLOTS,
    parameter int IW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic [IW-1:0] i_rd_addr,
    output logic      [IW-1:0] o_rd_next,
    output logic      [IW-1:0] o_rd_prev,
    input  wire logic          i_next_we,
    input  wire logic [IW-1:0] i_next_addr,
    input  wire logic [IW-1:0] i_next_data,
    input  wire logic          i_prev_we,
    input  wire logic [IW-1:0] i_prev_addr,
    input  wire logic [IW-1:0] i_prev_data
);

    logic [IW-1:0] r_next_mem [DEPTH];
    logic [IW-1:0] r_prev_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_next_we) begin
            r_next_mem[i_next_addr] <= i_next_data;
        end
        o_rd_next <= r_next_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_prev_we) begin
            r_prev_mem[i_prev_addr] <= i_prev_data;
        end
        o_rd_prev <= r_prev_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

>>> rtl/core/spa_free_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spa_free_search
// Priority encoder that finds the lowest inactive slot below the usable
// pool size.
// ----------------------------------------------------------------------------
module spa_free_search
    import spa_pkg::*;
#(
    parameter int DEPTH = SPA_MAX_SLOTS,
    parameter int IW    = 6,
    parameter int LW    = 7
) (
    input  wire logic [DEPTH-1:0] i_active,
    input  wire logic [LW-1:0]    i_limit,
    output logic                  o_found,
    output logic      [IW-1:0]    o_idx
);

    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!i_active[i] && (LW'(i) < i_limit)) begin
                o_found = 1'b1;
                o_idx   = IW'(i);
            end
        end
    end

endmodule
`default_nettype wire
